FILE: sv/gbn_pkg.sv
package gbn_pkg;

   localparam int unsigned FRAME_INDEX_BITS_DEF = 16;
   localparam int unsigned MAX_WINDOW_DEF = 32;
   localparam int unsigned RESULT_CAP = 32;

   localparam int unsigned MOD_W = 9;
   localparam int unsigned WIN_W = 6;
   localparam int unsigned TICK_W = 8;
   localparam int unsigned SEQ_W = 8;
   localparam int unsigned REQ_W = 3;
   localparam int unsigned KIND_W = 3;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 9;

   localparam logic [MOD_W-1:0] MOD_MIN = MOD_W'(2);
   localparam logic [MOD_W-1:0] MOD_MAX = MOD_W'(256);
   localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(8);
   localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(5);
   localparam logic [TICK_W-1:0] TICKS_RESET = TICK_W'(3);

   typedef enum logic [REQ_W-1:0] {
      REQ_START = 3'd0,
      REQ_TICK  = 3'd1,
      REQ_ACK   = 3'd2,
      REQ_NAK   = 3'd3,
      REQ_DATA  = 3'd4,
      REQ_END   = 3'd5
   } req_kind_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_DATA    = 3'd0,
      KIND_ACK     = 3'd1,
      KIND_NAK     = 3'd2,
      KIND_DISCARD = 3'd3,
      KIND_END     = 3'd4
   } out_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_NEW     = 2'd0,
      STAT_NAK     = 2'd1,
      STAT_TIMEOUT = 2'd2
   } send_status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEQ_MODULUS   = 2'd0,
      CSR_SEND_WINDOW   = 2'd1,
      CSR_TIMEOUT_TICKS = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      SEL_ACKED    = 2'd0,
      SEL_NEXT     = 2'd1,
      SEL_TOTAL    = 2'd2,
      SEL_EXPECTED = 2'd3
   } mod_sel_type;

   typedef struct packed {
      logic         latch_req;
      logic         start_xfer;
      logic         tick_inc;
      logic         timeout;
      logic         nak_rewind;
      logic         ack_inc;
      logic         stop_timer;
      logic         mod_start;
      mod_sel_type  mod_sel;
      logic         nextmod_copy;
      logic         calc_limit;
      logic         emit;
      out_kind_type emit_kind;
      logic         emit_last;
      logic         burst_step;
      logic         timer_arm;
      logic         end_clear;
      logic         exp_clear;
   } gbn_cmd_type;

   typedef struct packed {
      logic [REQ_W-1:0] req_type;
      logic             busy;
      logic             timer_running;
      logic             timer_expire;
      logic             hs_valid;
      logic             ack_beyond_hs;
      logic             cnt_zero;
      logic             acked_last;
      logic             next_eq_acked;
      logic             burst_more;
      logic             burst_last;
      logic             nak_match;
      logic             seq_match;
      logic             crc_ok;
      logic             mod_done;
      logic             slot_free;
   } gbn_status_type;

endpackage

FILE: sv/gbn_req_if.sv
interface gbn_req_if import gbn_pkg::*; #(
   parameter int unsigned FRAME_INDEX_BITS = FRAME_INDEX_BITS_DEF
);
   logic                        valid;
   logic                        ready;
   logic [REQ_W-1:0]            req_type;
   logic [FRAME_INDEX_BITS-1:0] frame_count;
   logic [SEQ_W-1:0]            seq_number;
   logic [SEQ_W-1:0]            ack_number;
   logic                        crc_ok;

   modport source (
      output valid, req_type, frame_count, seq_number, ack_number, crc_ok,
      input  ready
   );

   modport sink (
      input  valid, req_type, frame_count, seq_number, ack_number, crc_ok,
      output ready
   );
endinterface

FILE: sv/gbn_rsp_if.sv
interface gbn_rsp_if import gbn_pkg::*; #(
   parameter int unsigned FRAME_INDEX_BITS = FRAME_INDEX_BITS_DEF
);
   logic                        valid;
   logic                        ready;
   logic [KIND_W-1:0]           out_kind;
   logic [FRAME_INDEX_BITS-1:0] frame_index;
   logic [SEQ_W-1:0]            wire_seq;
   logic [SEQ_W-1:0]            wire_ack;
   logic [STATUS_W-1:0]         send_status;
   logic                        last_result;

   modport source (
      output valid, out_kind, frame_index, wire_seq, wire_ack, send_status, last_result,
      input  ready
   );

   modport sink (
      input  valid, out_kind, frame_index, wire_seq, wire_ack, send_status, last_result,
      output ready
   );
endinterface

FILE: sv/gbn_rem.sv
module gbn_rem import gbn_pkg::*; #(
   parameter int unsigned DIVIDEND_W = FRAME_INDEX_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [MOD_W-1:0]      divisor,
   output logic                  done,
   output logic [SEQ_W-1:0]      remainder
);

   localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  active_ff, active_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [MOD_W-1:0]      rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] dvd_ff, dvd_in;

   logic [MOD_W:0]   trial;
   logic [MOD_W:0]   trial_sub;
   logic [MOD_W-1:0] rem_step;
   logic             last;

   // one dividend bit per cycle, restoring
   always_comb begin
      trial = {rem_ff, dvd_ff[DIVIDEND_W-1]};
      trial_sub = trial - {1'b0, divisor};
      rem_step = (trial >= {1'b0, divisor}) ? trial_sub[MOD_W-1:0] : trial[MOD_W-1:0];
      last = active_ff && (cnt_ff == CNT_W'(1));
   end

   assign done = last;
   assign remainder = rem_step[SEQ_W-1:0];

   always_comb begin
      active_in = active_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in = CNT_W'(DIVIDEND_W);
         rem_in = '0;
         dvd_in = dividend;
      end else if (active_ff) begin
         rem_in = rem_step;
         dvd_in = {dvd_ff[DIVIDEND_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (last) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         active_ff <= active_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

endmodule

FILE: sv/gbn_dp.sv
module gbn_dp import gbn_pkg::*; #(
   parameter int unsigned FRAME_INDEX_BITS = FRAME_INDEX_BITS_DEF,
   parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  gbn_cmd_type                 cmd,
   output gbn_status_type              status,
   input  logic [REQ_W-1:0]            req_type,
   input  logic [FRAME_INDEX_BITS-1:0] frame_count,
   input  logic [SEQ_W-1:0]            seq_number,
   input  logic [SEQ_W-1:0]            ack_number,
   input  logic                        crc_ok,
   input  logic                        csr_write_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [KIND_W-1:0]           rsp_out_kind,
   output logic [FRAME_INDEX_BITS-1:0] rsp_frame_index,
   output logic [SEQ_W-1:0]            rsp_wire_seq,
   output logic [SEQ_W-1:0]            rsp_wire_ack,
   output logic [STATUS_W-1:0]         rsp_send_status,
   output logic                        rsp_last_result
);

   localparam int unsigned FIB = FRAME_INDEX_BITS;
   localparam int unsigned WIN_CAP = (MAX_WINDOW < RESULT_CAP) ? MAX_WINDOW : RESULT_CAP;
   localparam int unsigned DIV_W = (FIB > SEQ_W + 1) ? FIB : SEQ_W + 1;

   // latched beat
   logic [REQ_W-1:0] req_type_ff, req_type_in;
   logic [FIB-1:0]   count_ff, count_in;
   logic [SEQ_W-1:0] seq_ff, seq_in;
   logic [SEQ_W-1:0] nak_ff, nak_in;
   logic             crc_ff, crc_in;

   // configuration
   logic [MOD_W-1:0]  mod_ff, mod_in;
   logic [WIN_W-1:0]  win_ff, win_in;
   logic [TICK_W-1:0] ticks_ff, ticks_in;

   // sender and receiver state
   logic [FIB-1:0]    total_ff, total_in;
   logic [FIB-1:0]    acked_ff, acked_in;
   logic [FIB-1:0]    next_ff, next_in;
   logic [FIB-1:0]    hs_ff, hs_in;
   logic              hs_valid_ff, hs_valid_in;
   logic              nak_flag_ff, nak_flag_in;
   logic              tout_flag_ff, tout_flag_in;
   logic              busy_ff, busy_in;
   logic              timer_run_ff, timer_run_in;
   logic [TICK_W-1:0] timer_cnt_ff, timer_cnt_in;
   logic [SEQ_W-1:0]  exp_ff, exp_in;

   // sequence numbers modulo the effective modulus
   logic [SEQ_W-1:0] ackmod_ff, ackmod_in;
   logic [SEQ_W-1:0] nextmod_ff, nextmod_in;
   logic [SEQ_W-1:0] totalmod_ff, totalmod_in;
   logic [FIB:0]     limit_ff, limit_in;
   mod_sel_type      mod_sel_ff, mod_sel_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [FIB-1:0]      index_ff, index_in;
   logic [SEQ_W-1:0]    wseq_ff, wseq_in;
   logic [SEQ_W-1:0]    wack_ff, wack_in;
   logic [STATUS_W-1:0] sstat_ff, sstat_in;
   logic                last_ff, last_in;

   logic [MOD_W-1:0]  mod_eff;
   logic [WIN_W-1:0]  win_eff;
   logic [TICK_W-1:0] ticks_eff;
   logic [TICK_W-1:0] timer_inc;
   logic [FIB-1:0]    acked_plus1;
   logic [FIB-1:0]    rem_frames;
   logic [FIB-1:0]    cur_win;
   logic [FIB:0]      limit_calc;
   logic [FIB:0]      next_plus1;
   logic              is_new;
   send_status_type   data_status;
   logic [MOD_W-1:0]  nextmod_inc;
   logic [SEQ_W:0]    exp_inc;
   logic [DIV_W-1:0]  dividend;
   logic              mod_done;
   logic [SEQ_W-1:0]  mod_result;
   logic              slot_free;

   always_comb begin
      mod_eff = mod_ff;
      if (mod_ff < MOD_MIN) begin
         mod_eff = MOD_MIN;
      end else if (mod_ff > MOD_MAX) begin
         mod_eff = MOD_MAX;
      end
      win_eff = win_ff;
      if (win_ff == '0) begin
         win_eff = WIN_W'(1);
      end else if (win_ff > WIN_W'(WIN_CAP)) begin
         win_eff = WIN_W'(WIN_CAP);
      end
      ticks_eff = (ticks_ff == '0) ? TICK_W'(1) : ticks_ff;
      timer_inc = timer_cnt_ff + TICK_W'(1);
      acked_plus1 = acked_ff + FIB'(1);
      rem_frames = total_ff - acked_ff;
      cur_win = (rem_frames < FIB'(win_eff)) ? rem_frames : FIB'(win_eff);
      limit_calc = {1'b0, acked_ff} + {1'b0, cur_win};
      next_plus1 = {1'b0, next_ff} + (FIB + 1)'(1);
      is_new = !hs_valid_ff || (next_ff > hs_ff);
      if (is_new) begin
         data_status = STAT_NEW;
      end else if (nak_flag_ff) begin
         data_status = STAT_NAK;
      end else if (tout_flag_ff) begin
         data_status = STAT_TIMEOUT;
      end else begin
         data_status = STAT_NEW;
      end
      nextmod_inc = {1'b0, nextmod_ff} + MOD_W'(1);
      exp_inc = {1'b0, exp_ff} + (SEQ_W + 1)'(1);
      slot_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      unique case (cmd.mod_sel)
         SEL_ACKED:    dividend = DIV_W'(acked_ff);
         SEL_NEXT:     dividend = DIV_W'(next_ff);
         SEL_TOTAL:    dividend = DIV_W'(total_ff);
         SEL_EXPECTED: dividend = DIV_W'(exp_inc);
         default:      dividend = '0;
      endcase
   end

   gbn_rem #(
      .DIVIDEND_W(DIV_W)
   ) u_rem (
      .clock(clock),
      .reset(reset),
      .start(cmd.mod_start),
      .dividend(dividend),
      .divisor(mod_eff),
      .done(mod_done),
      .remainder(mod_result)
   );

   always_comb begin
      status.req_type = req_type_ff;
      status.busy = busy_ff;
      status.timer_running = timer_run_ff;
      status.timer_expire = timer_inc >= ticks_eff;
      status.hs_valid = hs_valid_ff;
      status.ack_beyond_hs = acked_ff > hs_ff;
      status.cnt_zero = count_ff == '0;
      status.acked_last = acked_plus1 >= total_ff;
      status.next_eq_acked = next_ff == acked_ff;
      status.burst_more = {1'b0, next_ff} < limit_ff;
      status.burst_last = next_plus1 >= limit_ff;
      status.nak_match = nak_ff == ackmod_ff;
      status.seq_match = seq_ff == exp_ff;
      status.crc_ok = crc_ff;
      status.mod_done = mod_done;
      status.slot_free = slot_free;
   end

   always_comb begin
      req_type_in = req_type_ff;
      count_in = count_ff;
      seq_in = seq_ff;
      nak_in = nak_ff;
      crc_in = crc_ff;
      mod_in = mod_ff;
      win_in = win_ff;
      ticks_in = ticks_ff;
      total_in = total_ff;
      acked_in = acked_ff;
      next_in = next_ff;
      hs_in = hs_ff;
      hs_valid_in = hs_valid_ff;
      nak_flag_in = nak_flag_ff;
      tout_flag_in = tout_flag_ff;
      busy_in = busy_ff;
      timer_run_in = timer_run_ff;
      timer_cnt_in = timer_cnt_ff;
      exp_in = exp_ff;
      ackmod_in = ackmod_ff;
      nextmod_in = nextmod_ff;
      totalmod_in = totalmod_ff;
      limit_in = limit_ff;
      mod_sel_in = mod_sel_ff;
      rsp_valid_in = rsp_valid_ff;
      kind_in = kind_ff;
      index_in = index_ff;
      wseq_in = wseq_ff;
      wack_in = wack_ff;
      sstat_in = sstat_ff;
      last_in = last_ff;

      if (cmd.latch_req) begin
         req_type_in = req_type;
         count_in = frame_count;
         seq_in = seq_number;
         nak_in = ack_number;
         crc_in = crc_ok;
      end

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_SEQ_MODULUS:   mod_in = csr_wdata[MOD_W-1:0];
            CSR_SEND_WINDOW:   win_in = csr_wdata[WIN_W-1:0];
            CSR_TIMEOUT_TICKS: ticks_in = csr_wdata[TICK_W-1:0];
            default: ;
         endcase
      end

      if (cmd.start_xfer) begin
         total_in = count_ff;
         acked_in = '0;
         next_in = '0;
         hs_valid_in = 1'b0;
         nak_flag_in = 1'b0;
         tout_flag_in = 1'b0;
         busy_in = count_ff != '0;
         timer_run_in = 1'b0;
         timer_cnt_in = '0;
         ackmod_in = '0;
         nextmod_in = '0;
         totalmod_in = '0;
      end

      if (cmd.tick_inc) begin
         timer_cnt_in = timer_inc;
      end

      if (cmd.timeout) begin
         timer_run_in = 1'b0;
         tout_flag_in = 1'b1;
         next_in = acked_ff;
      end

      if (cmd.nak_rewind) begin
         nak_flag_in = 1'b1;
         timer_run_in = 1'b0;
         next_in = acked_ff;
      end

      // acked frames are never resent
      if (cmd.ack_inc) begin
         acked_in = acked_plus1;
         if (next_ff < acked_plus1) begin
            next_in = acked_plus1;
         end
      end

      if (cmd.stop_timer) begin
         timer_run_in = 1'b0;
      end

      if (cmd.mod_start) begin
         mod_sel_in = cmd.mod_sel;
      end

      if (mod_done) begin
         unique case (mod_sel_ff)
            SEL_ACKED:    ackmod_in = mod_result;
            SEL_NEXT:     nextmod_in = mod_result;
            SEL_TOTAL:    totalmod_in = mod_result;
            SEL_EXPECTED: exp_in = mod_result;
            default: ;
         endcase
      end

      if (cmd.nextmod_copy) begin
         nextmod_in = ackmod_ff;
      end

      if (cmd.calc_limit) begin
         limit_in = limit_calc;
      end

      if (cmd.burst_step) begin
         if (is_new) begin
            hs_in = next_ff;
            hs_valid_in = 1'b1;
            nak_flag_in = 1'b0;
            tout_flag_in = 1'b0;
         end
         next_in = next_ff + FIB'(1);
         nextmod_in = (nextmod_inc == mod_eff) ? '0 : nextmod_inc[SEQ_W-1:0];
      end

      if (cmd.timer_arm && !timer_run_ff) begin
         timer_run_in = 1'b1;
         timer_cnt_in = '0;
      end

      // total_frames is kept
      if (cmd.end_clear) begin
         acked_in = '0;
         next_in = '0;
         hs_valid_in = 1'b0;
         nak_flag_in = 1'b0;
         tout_flag_in = 1'b0;
         busy_in = 1'b0;
         timer_run_in = 1'b0;
         timer_cnt_in = '0;
      end

      if (cmd.exp_clear) begin
         exp_in = '0;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         kind_in = cmd.emit_kind;
         last_in = cmd.emit_last;
         unique case (cmd.emit_kind)
            KIND_DATA: begin
               index_in = next_ff;
               wseq_in = nextmod_ff;
               wack_in = ackmod_ff;
               sstat_in = data_status;
            end
            KIND_END: begin
               index_in = total_ff;
               wseq_in = totalmod_ff;
               wack_in = ackmod_ff;
               sstat_in = STAT_NEW;
            end
            default: begin
               index_in = '0;
               wseq_in = seq_ff;
               wack_in = exp_ff;
               sstat_in = STAT_NEW;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= MOD_RESET;
         win_ff <= WIN_RESET;
         ticks_ff <= TICKS_RESET;
         total_ff <= '0;
         acked_ff <= '0;
         next_ff <= '0;
         hs_ff <= '0;
         hs_valid_ff <= 1'b0;
         nak_flag_ff <= 1'b0;
         tout_flag_ff <= 1'b0;
         busy_ff <= 1'b0;
         timer_run_ff <= 1'b0;
         timer_cnt_ff <= '0;
         exp_ff <= '0;
         ackmod_ff <= '0;
         nextmod_ff <= '0;
         totalmod_ff <= '0;
         limit_ff <= '0;
         mod_sel_ff <= SEL_ACKED;
         rsp_valid_ff <= 1'b0;
      end else begin
         mod_ff <= mod_in;
         win_ff <= win_in;
         ticks_ff <= ticks_in;
         total_ff <= total_in;
         acked_ff <= acked_in;
         next_ff <= next_in;
         hs_ff <= hs_in;
         hs_valid_ff <= hs_valid_in;
         nak_flag_ff <= nak_flag_in;
         tout_flag_ff <= tout_flag_in;
         busy_ff <= busy_in;
         timer_run_ff <= timer_run_in;
         timer_cnt_ff <= timer_cnt_in;
         exp_ff <= exp_in;
         ackmod_ff <= ackmod_in;
         nextmod_ff <= nextmod_in;
         totalmod_ff <= totalmod_in;
         limit_ff <= limit_in;
         mod_sel_ff <= mod_sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_type_ff <= req_type_in;
      count_ff <= count_in;
      seq_ff <= seq_in;
      nak_ff <= nak_in;
      crc_ff <= crc_in;
      kind_ff <= kind_in;
      index_ff <= index_in;
      wseq_ff <= wseq_in;
      wack_ff <= wack_in;
      sstat_ff <= sstat_in;
      last_ff <= last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_kind = kind_ff;
   assign rsp_frame_index = index_ff;
   assign rsp_wire_seq = wseq_ff;
   assign rsp_wire_ack = wack_ff;
   assign rsp_send_status = sstat_ff;
   assign rsp_last_result = last_ff;

endmodule

FILE: sv/gbn_ctrl.sv
module gbn_ctrl import gbn_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  gbn_status_type status,
   output gbn_cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_WAIT_ACK_B,
      S_PREP,
      S_WAIT_NEXT,
      S_LIMIT,
      S_BURST,
      S_ACK_LIM,
      S_ACK_CHECK,
      S_ACK_END,
      S_WAIT_ACK_E,
      S_WAIT_TOT,
      S_EMIT_END,
      S_WAIT_ACK_N,
      S_NAK_CHECK,
      S_WAIT_EXP,
      S_RX_ACK,
      S_RX_NAK,
      S_RX_DISCARD
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = state_ff == S_IDLE;
      cmd.latch_req = req_ready && req_valid;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_IDLE;
            unique case (status.req_type)
               REQ_START: begin
                  if (!status.busy) begin
                     cmd.start_xfer = 1'b1;
                     state_in = status.cnt_zero ? S_EMIT_END : S_LIMIT;
                  end
               end
               REQ_TICK: begin
                  if (status.busy && status.timer_running) begin
                     cmd.tick_inc = 1'b1;
                     if (status.timer_expire) begin
                        cmd.timeout = 1'b1;
                        cmd.mod_start = 1'b1;
                        cmd.mod_sel = SEL_ACKED;
                        state_in = S_WAIT_ACK_B;
                     end
                  end
               end
               REQ_ACK: begin
                  if (status.busy && status.hs_valid && !status.ack_beyond_hs) begin
                     cmd.ack_inc = 1'b1;
                     state_in = status.acked_last ? S_ACK_END : S_ACK_LIM;
                  end
               end
               REQ_NAK: begin
                  if (status.busy) begin
                     cmd.mod_start = 1'b1;
                     cmd.mod_sel = SEL_ACKED;
                     state_in = S_WAIT_ACK_N;
                  end
               end
               REQ_DATA: begin
                  if (!status.seq_match) begin
                     state_in = S_RX_DISCARD;
                  end else if (status.crc_ok) begin
                     cmd.mod_start = 1'b1;
                     cmd.mod_sel = SEL_EXPECTED;
                     state_in = S_WAIT_EXP;
                  end else begin
                     state_in = S_RX_NAK;
                  end
               end
               REQ_END: begin
                  cmd.exp_clear = 1'b1;
               end
               default: ;
            endcase
         end
         S_WAIT_ACK_B: begin
            if (status.mod_done) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            if (status.next_eq_acked) begin
               cmd.nextmod_copy = 1'b1;
               state_in = S_LIMIT;
            end else begin
               cmd.mod_start = 1'b1;
               cmd.mod_sel = SEL_NEXT;
               state_in = S_WAIT_NEXT;
            end
         end
         S_WAIT_NEXT: begin
            if (status.mod_done) begin
               state_in = S_LIMIT;
            end
         end
         S_LIMIT: begin
            cmd.calc_limit = 1'b1;
            state_in = S_BURST;
         end
         S_BURST: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.emit_kind = KIND_DATA;
               cmd.emit_last = status.burst_last;
               cmd.burst_step = 1'b1;
               if (status.burst_last) begin
                  cmd.timer_arm = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         S_ACK_LIM: begin
            cmd.calc_limit = 1'b1;
            state_in = S_ACK_CHECK;
         end
         S_ACK_CHECK: begin
            if (status.burst_more) begin
               cmd.stop_timer = 1'b1;
               cmd.mod_start = 1'b1;
               cmd.mod_sel = SEL_ACKED;
               state_in = S_WAIT_ACK_B;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_ACK_END: begin
            cmd.mod_start = 1'b1;
            cmd.mod_sel = SEL_ACKED;
            state_in = S_WAIT_ACK_E;
         end
         S_WAIT_ACK_E: begin
            if (status.mod_done) begin
               cmd.mod_start = 1'b1;
               cmd.mod_sel = SEL_TOTAL;
               state_in = S_WAIT_TOT;
            end
         end
         S_WAIT_TOT: begin
            if (status.mod_done) begin
               state_in = S_EMIT_END;
            end
         end
         S_EMIT_END: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.emit_kind = KIND_END;
               cmd.emit_last = 1'b1;
               cmd.end_clear = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_WAIT_ACK_N: begin
            if (status.mod_done) begin
               state_in = S_NAK_CHECK;
            end
         end
         S_NAK_CHECK: begin
            if (status.nak_match) begin
               cmd.nak_rewind = 1'b1;
               state_in = S_PREP;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_WAIT_EXP: begin
            if (status.mod_done) begin
               state_in = S_RX_ACK;
            end
         end
         S_RX_ACK: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.emit_kind = KIND_ACK;
               cmd.emit_last = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_RX_NAK: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.emit_kind = KIND_NAK;
               cmd.emit_last = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_RX_DISCARD: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.emit_kind = KIND_DISCARD;
               cmd.emit_last = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/go_back_n_arq_endpoint.sv
// input ready only in idle, reached from decode or after the last result
// seq_modulus reductions run bit-serially over max(FRAME_INDEX_BITS, 9) dividend bits
// first result after the beat: start, discard and rx nak need no reduction, good frame one,
// timeout and nak one, opened window one or two, final ack two
// a burst then issues one data frame a cycle while rsp_ready holds
// synchronous active-high reset: registers 8, 5, 3, sender idle, expected sequence 0
module go_back_n_arq_endpoint import gbn_pkg::*; #(
   parameter int unsigned FRAME_INDEX_BITS = FRAME_INDEX_BITS_DEF,
   parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   gbn_req_if.sink               req_bus,
   gbn_rsp_if.source             rsp_bus,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   gbn_cmd_type    cmd;
   gbn_status_type status;
   logic           req_ready;

   gbn_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_bus.valid),
      .req_ready(req_ready),
      .status(status),
      .cmd(cmd)
   );

   gbn_dp #(
      .FRAME_INDEX_BITS(FRAME_INDEX_BITS),
      .MAX_WINDOW(MAX_WINDOW)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .req_type(req_bus.req_type),
      .frame_count(req_bus.frame_count),
      .seq_number(req_bus.seq_number),
      .ack_number(req_bus.ack_number),
      .crc_ok(req_bus.crc_ok),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .rsp_valid(rsp_bus.valid),
      .rsp_ready(rsp_bus.ready),
      .rsp_out_kind(rsp_bus.out_kind),
      .rsp_frame_index(rsp_bus.frame_index),
      .rsp_wire_seq(rsp_bus.wire_seq),
      .rsp_wire_ack(rsp_bus.wire_ack),
      .rsp_send_status(rsp_bus.send_status),
      .rsp_last_result(rsp_bus.last_result)
   );

   assign req_bus.ready = req_ready;

endmodule
